>>> sv/integer_run_set_unit_defines.svh
// assertion macros shared by the run set unit
`ifndef INTEGER_RUN_SET_UNIT_DEFINES_SVH
`define INTEGER_RUN_SET_UNIT_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define IRS_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("run set check failed");

// condition in one cycle implies a consequence in the next
`define IRS_ASSERT_NEXT(name, cond, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error("run set sequence check failed");

`endif

>>> sv/irs_pkg.sv
// ----------------------------------------------------------------------------
// irs_pkg
// Shared types and codes of the integer run set unit.
// ----------------------------------------------------------------------------
`default_nettype none

package irs_pkg;

    localparam int MAX_RUNS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    // request codes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;

    // status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NOCHG = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // edit broadcast to the cell row
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_MERGE,
        ACT_LEFT,
        ACT_RIGHT,
        ACT_NEW,
        ACT_DROP,
        ACT_LOW,
        ACT_HIGH,
        ACT_SPLIT
    } t_act;

    typedef struct packed {
        logic cmp;
        t_act act;
    } t_cmd;

    // control bits one cell shows its neighbors
    typedef struct packed {
        logic below;
        logic at;
        logic adjhi;
        logic valid;
    } t_link;

    // per-cell search results, or-reduced at the top
    typedef struct packed {
        logic pres;
        logic jl;
        logic jr;
        logic eqlo;
        logic eqhi;
    } t_flags;

endpackage

`default_nettype wire

>>> sv/irs_req_if.sv
// ----------------------------------------------------------------------------
// irs_req_if
// Request channel: one word carries an operation and a value.
// ----------------------------------------------------------------------------
`default_nettype none

interface irs_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic signed [31:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

`default_nettype wire

>>> sv/irs_res_if.sv
// ----------------------------------------------------------------------------
// irs_res_if
// Result channel: one word summarizes the set after a request.
// ----------------------------------------------------------------------------
`default_nettype none

interface irs_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               was_present;
    logic [32:0]        element_count;
    logic [6:0]         used_runs;
    logic               is_empty;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;

    modport source (output valid, output status, output was_present, output element_count,
                    output used_runs, output is_empty, output min_value, output max_value,
                    input ready);
    modport sink   (input valid, input status, input was_present, input element_count,
                    input used_runs, input is_empty, input min_value, input max_value,
                    output ready);
endinterface

`default_nettype wire

>>> sv/irs_cell.sv
// ----------------------------------------------------------------------------
// irs_cell
// One slot of the run table: holds a run, compares it with the key and
// shifts to or from its neighbors on an edit.
// ----------------------------------------------------------------------------
`default_nettype none

module irs_cell import irs_pkg::*; #(
    parameter int VB = VALUE_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cmd          i_cmd,
    input  wire logic [VB-1:0] i_key,
    input  wire t_link         i_left,
    input  wire logic [VB-1:0] i_left_lo,
    input  wire logic [VB-1:0] i_left_hi,
    input  wire t_link         i_right,
    input  wire logic [VB-1:0] i_right_lo,
    input  wire logic [VB-1:0] i_right_hi,
    output t_link              o_link,
    output logic [VB-1:0]      o_lo,
    output logic [VB-1:0]      o_hi,
    output t_flags             o_flags,
    output logic [VB-1:0]      o_last_hi
);

    logic [VB-1:0] r_lo, r_hi, n_lo, n_hi;
    logic          r_valid, n_valid;
    logic          r_below, r_gelo, r_adjhi, r_adjlo, r_eqlo, r_eqhi;
    logic          w_at, w_ge, w_gt, w_gt1;
    logic [VB-1:0] w_kp1, w_km1;

    // position of this slot relative to the search index
    assign w_at  = !r_below && i_left.below;
    assign w_ge  = !r_below;
    assign w_gt  = !i_left.below;
    assign w_gt1 = !i_left.below && !i_left.at;
    assign w_kp1 = i_key + 1'b1;
    assign w_km1 = i_key - 1'b1;

    // next contents for the broadcast edit
    always_comb begin
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_valid = r_valid;
        unique case (i_cmd.act)
            ACT_MERGE: begin
                if (i_right.at) n_hi = i_right_hi;
                if (w_ge) begin
                    n_lo    = i_right_lo;
                    n_hi    = i_right_hi;
                    n_valid = i_right.valid;
                end
            end
            ACT_LEFT: begin
                if (i_right.at) n_hi = i_key;
            end
            ACT_RIGHT: begin
                if (w_at) n_lo = i_key;
            end
            ACT_NEW: begin
                if (w_at) begin
                    n_lo    = i_key;
                    n_hi    = i_key;
                    n_valid = 1'b1;
                end else if (w_gt) begin
                    n_lo    = i_left_lo;
                    n_hi    = i_left_hi;
                    n_valid = i_left.valid;
                end
            end
            ACT_DROP: begin
                if (w_ge) begin
                    n_lo    = i_right_lo;
                    n_hi    = i_right_hi;
                    n_valid = i_right.valid;
                end
            end
            ACT_LOW: begin
                if (w_at) n_lo = w_kp1;
            end
            ACT_HIGH: begin
                if (w_at) n_hi = w_km1;
            end
            ACT_SPLIT: begin
                if (w_at) begin
                    n_hi = w_km1;
                end else if (i_left.at) begin
                    n_lo    = w_kp1;
                    n_hi    = i_left_hi;
                    n_valid = 1'b1;
                end else if (w_gt1) begin
                    n_lo    = i_left_lo;
                    n_hi    = i_left_hi;
                    n_valid = i_left.valid;
                end
            end
            default: ;
        endcase
    end

    // run contents and occupancy
    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // compare against the key
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_below <= r_valid && (r_hi < i_key);
            r_gelo  <= r_lo <= i_key;
            r_adjhi <= r_valid && (({1'b0, r_hi} + 1'b1) == {1'b0, i_key});
            r_adjlo <= {1'b0, r_lo} == ({1'b0, i_key} + 1'b1);
            r_eqlo  <= r_lo == i_key;
            r_eqhi  <= r_hi == i_key;
        end
    end

    // neighbor view and search results
    assign o_link    = '{below: r_below, at: w_at, adjhi: r_adjhi, valid: r_valid};
    assign o_lo      = r_lo;
    assign o_hi      = r_hi;
    assign o_flags   = '{pres: w_at && r_valid && r_gelo,
                         jl:   w_at && i_left.adjhi,
                         jr:   w_at && r_valid && r_adjlo,
                         eqlo: w_at && r_valid && r_eqlo,
                         eqhi: w_at && r_valid && r_eqhi};
    assign o_last_hi = (r_valid && !i_right.valid) ? r_hi : '0;

endmodule

`default_nettype wire

>>> sv/integer_run_set_unit.sv
// ----------------------------------------------------------------------------
// integer_run_set_unit
// Set of signed integers kept as a sorted row of runs, one run per cell.
// ----------------------------------------------------------------------------
//  channel   dir  fields
//  i_req     in   req_type, value
//  o_res     out  status, was_present, element_count, used_runs, is_empty,
//                 min_value, max_value
//
//  a request passes from accept to result through key capture, parallel
//  compare in every cell, edit with one neighbor shift, result build.
//  one request is in flight at a time; i_req.ready is high only when idle.
//  reset clears the run count and cell valid bits.
//  a result waits in the output register while o_res.ready is low.
// ----------------------------------------------------------------------------
`default_nettype none
`include "integer_run_set_unit_defines.svh"

module integer_run_set_unit import irs_pkg::*; #(
    parameter int MAX_RUNS   = MAX_RUNS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    irs_req_if.sink  i_req,
    irs_res_if.source o_res
);

    localparam int VB = VALUE_BITS;
    localparam int TW = $clog2(MAX_RUNS + 1);
    localparam logic [VB-1:0] SIGN = {1'b1, {(VB-1){1'b0}}};

    typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD, S_OUT} t_state;

    t_state        r_state;
    logic [VB-1:0] r_key;
    logic [1:0]    r_op;
    logic [TW-1:0] r_total;
    logic [32:0]   r_count;
    logic [1:0]    r_status;
    logic          r_present;
    logic          r_out_valid;
    logic [1:0]    r_o_status;
    logic          r_o_present;
    logic [32:0]   r_o_count;
    logic [6:0]    r_o_runs;
    logic          r_o_empty;
    logic [31:0]   r_o_min, r_o_max;

    t_cmd          w_cmd;
    t_act          w_act;
    logic [1:0]    w_status;
    t_link         w_link [MAX_RUNS];
    logic [VB-1:0] w_lo [MAX_RUNS];
    logic [VB-1:0] w_hi [MAX_RUNS];
    t_flags        w_flags [MAX_RUNS];
    logic [VB-1:0] w_last [MAX_RUNS];
    t_flags        w_any;
    logic          w_jl;
    logic [VB-1:0] w_max_key;
    logic signed [VB-1:0] w_min_s, w_max_s;
    logic signed [VB-1:0] w_in_s;

    // row of cells
    for (genvar g = 0; g < MAX_RUNS; g++) begin : g_cell
        t_link         l_left, l_right;
        logic [VB-1:0] l_llo, l_lhi, l_rlo, l_rhi;
        if (g == 0) begin : g_first
            assign l_left = '{below: 1'b1, at: 1'b0, adjhi: 1'b0, valid: 1'b1};
            assign l_llo  = '0;
            assign l_lhi  = '0;
        end else begin : g_mid_l
            assign l_left = w_link[g-1];
            assign l_llo  = w_lo[g-1];
            assign l_lhi  = w_hi[g-1];
        end
        if (g == MAX_RUNS - 1) begin : g_last
            // slot past the row is the search index when every run is below the key
            assign l_right = '{below: 1'b0, at: w_link[g].below, adjhi: 1'b0, valid: 1'b0};
            assign l_rlo   = '0;
            assign l_rhi   = '0;
        end else begin : g_mid_r
            assign l_right = w_link[g+1];
            assign l_rlo   = w_lo[g+1];
            assign l_rhi   = w_hi[g+1];
        end
        irs_cell #(.VB(VB)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (w_cmd),
            .i_key      (r_key),
            .i_left     (l_left),
            .i_left_lo  (l_llo),
            .i_left_hi  (l_lhi),
            .i_right    (l_right),
            .i_right_lo (l_rlo),
            .i_right_hi (l_rhi),
            .o_link     (w_link[g]),
            .o_lo       (w_lo[g]),
            .o_hi       (w_hi[g]),
            .o_flags    (w_flags[g]),
            .o_last_hi  (w_last[g])
        );
    end

    // or-reduce search results and the top run bound
    always_comb begin
        w_any     = '0;
        w_max_key = '0;
        for (int k = 0; k < MAX_RUNS; k++) begin
            w_any     = w_any | w_flags[k];
            w_max_key = w_max_key | w_last[k];
        end
    end

    // join to the last cell when the search runs off the end of a full row
    assign w_jl = w_any.jl || (w_link[MAX_RUNS-1].below && w_link[MAX_RUNS-1].adjhi);

    // pick the edit
    always_comb begin
        w_act    = ACT_NONE;
        w_status = ST_DONE;
        if (r_op == OP_ADD) begin
            if (w_any.pres)                  w_status = ST_NOCHG;
            else if (w_jl && w_any.jr)       w_act = ACT_MERGE;
            else if (w_jl)                   w_act = ACT_LEFT;
            else if (w_any.jr)               w_act = ACT_RIGHT;
            else if (r_total >= TW'(MAX_RUNS)) w_status = ST_FULL;
            else                             w_act = ACT_NEW;
        end else if (r_op == OP_REMOVE) begin
            if (!w_any.pres)                   w_status = ST_NOCHG;
            else if (w_any.eqlo && w_any.eqhi) w_act = ACT_DROP;
            else if (w_any.eqlo)               w_act = ACT_LOW;
            else if (w_any.eqhi)               w_act = ACT_HIGH;
            else if (r_total >= TW'(MAX_RUNS)) w_status = ST_FULL;
            else                               w_act = ACT_SPLIT;
        end
    end

    assign w_cmd   = '{cmp: r_state == S_CMP, act: (r_state == S_UPD) ? w_act : ACT_NONE};
    assign w_in_s  = VB'(i_req.value);
    assign w_min_s = $signed(w_lo[0] ^ SIGN);
    assign w_max_s = $signed(w_max_key ^ SIGN);

    // sequencer, counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_res.ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_key   <= w_in_s ^ SIGN;
                        r_op    <= i_req.req_type;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: r_state <= S_UPD;
                S_UPD: begin
                    r_status  <= w_status;
                    r_present <= w_any.pres;
                    case (w_act)
                        ACT_MERGE:                            r_total <= r_total - 1'b1;
                        ACT_DROP:                             r_total <= r_total - 1'b1;
                        ACT_NEW, ACT_SPLIT:                   r_total <= r_total + 1'b1;
                        default: ;
                    endcase
                    case (w_act)
                        ACT_MERGE, ACT_LEFT, ACT_RIGHT, ACT_NEW: r_count <= r_count + 1'b1;
                        ACT_DROP, ACT_LOW, ACT_HIGH, ACT_SPLIT:  r_count <= r_count - 1'b1;
                        default: ;
                    endcase
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid <= 1'b1;
                        r_o_status  <= r_status;
                        r_o_present <= r_present;
                        r_o_count   <= r_count;
                        r_o_runs    <= 7'(r_total);
                        r_o_empty   <= r_total == '0;
                        r_o_min     <= (r_total == '0) ? '0 : 32'(w_min_s);
                        r_o_max     <= (r_total == '0) ? '0 : 32'(w_max_s);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready         = r_state == S_IDLE;
    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_o_status;
    assign o_res.was_present   = r_o_present;
    assign o_res.element_count = r_o_count;
    assign o_res.used_runs     = r_o_runs;
    assign o_res.is_empty      = r_o_empty;
    assign o_res.min_value     = r_o_min;
    assign o_res.max_value     = r_o_max;

    // checks
    `IRS_ASSERT_ALWAYS(a_total_bound, r_total <= TW'(MAX_RUNS))
    `IRS_ASSERT_ALWAYS(a_count_runs, (r_total == '0) == (r_count == '0))
    `IRS_ASSERT_NEXT(a_accept_cmp, i_req.valid && i_req.ready, r_state == S_CMP)
    `IRS_ASSERT_NEXT(a_upd_out, r_state == S_UPD, r_state == S_OUT)

endmodule

`default_nettype wire
